/* rtl/core/sse_pkg.sv */
package sse_pkg;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [30:0] RETRY_MAX = 31'h7FFF_FFFF;

  // Line phases.
  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_NAME  = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;
  localparam logic [1:0] PH_SKIP  = 2'd3;

  // Field kinds.
  localparam logic [2:0] FK_NONE  = 3'd0;
  localparam logic [2:0] FK_DATA  = 3'd1;
  localparam logic [2:0] FK_ID    = 3'd2;
  localparam logic [2:0] FK_EVENT = 3'd3;
  localparam logic [2:0] FK_RETRY = 3'd4;

  // Result kinds.
  localparam logic [2:0] K_DATA      = 3'd0;
  localparam logic [2:0] K_ID        = 3'd1;
  localparam logic [2:0] K_EVENT     = 3'd2;
  localparam logic [2:0] K_ID_CLR    = 3'd3;
  localparam logic [2:0] K_EVENT_CLR = 3'd4;
  localparam logic [2:0] K_RETRY     = 3'd5;
  localparam logic [2:0] K_DISPATCH  = 3'd6;
  localparam logic [2:0] K_DISCARD   = 3'd7;

  // Bit positions of the retry flags.
  localparam int RF_NEG   = 0;
  localparam int RF_DIGIT = 1;
  localparam int RF_BAD   = 2;
  localparam int RF_OVF   = 3;

  // Field names, zero padded to eight characters so a 3-bit position indexes them.
  localparam logic [7:0] NAME_TEXT [4][8] = '{
    '{8'h64, 8'h61, 8'h74, 8'h61, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h69, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h65, 8'h76, 8'h65, 8'h6E, 8'h74, 8'h00, 8'h00, 8'h00},
    '{8'h72, 8'h65, 8'h74, 8'h72, 8'h79, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [2:0] NAME_LEN [4] = '{3'd4, 3'd2, 3'd5, 3'd5};

  typedef struct packed {
    logic       func;
    logic [7:0] in_byte;
  } sse_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  out_byte;
    logic [30:0] retry_value;
    logic        last;
  } sse_out_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [3:0]  cand;
    logic [2:0]  pos;
    logic [2:0]  fkind;
    logic        vfirst;
    logic        has_field;
    logic        data_ne;
    logic [30:0] accum;
    logic [3:0]  flags;
  } sse_state_t;

  localparam sse_state_t STATE_RESET = '{
    phase: PH_START, cand: 4'hF, pos: 3'd0, fkind: FK_NONE, vfirst: 1'b0,
    has_field: 1'b0, data_ne: 1'b0, accum: 31'd0, flags: 4'd0
  };

  // Rule out every candidate name that cannot take byte b at position pos.
  function automatic logic [3:0] name_step(logic [3:0] cand, logic [2:0] pos,
                                           logic [7:0] b);
    logic [3:0] c;
    c = cand;
    for (int i = 0; i < 4; i++) begin
      if (cand[i] && ((pos >= NAME_LEN[i]) || (NAME_TEXT[i][pos] != b))) begin
        c[i] = 1'b0;
      end
    end
    return c;
  endfunction

  function automatic logic [2:0] name_resolve(logic [3:0] cand, logic [2:0] pos);
    logic [2:0] fk;
    fk = FK_NONE;
    for (int i = 3; i >= 0; i--) begin
      if (cand[i] && (pos == NAME_LEN[i])) begin
        fk = 3'(i + 1);
      end
    end
    return fk;
  endfunction

endpackage

/* rtl/core/sse_feed.sv */
module sse_feed (
  input  sse_pkg::sse_state_t st_i,
  input  logic [7:0]          byte_i,
  output sse_pkg::sse_state_t st_o,
  output logic                res_vld_o,
  output sse_pkg::sse_out_t   res_o
);
  import sse_pkg::*;

  logic        is_digit;
  logic [3:0]  digit;
  logic [34:0] prod;
  logic        ovf;
  logic        close_ok;
  logic [2:0]  fk;

  assign is_digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign digit    = 4'(byte_i - CH_ZERO);
  // Ten times the accumulator plus the digit, as two shifts and two adds.
  assign prod     = {1'b0, st_i.accum, 3'b000} + {3'b000, st_i.accum, 1'b0}
                  + {31'd0, digit};
  assign ovf      = prod > {4'd0, RETRY_MAX};
  assign close_ok = st_i.flags[RF_DIGIT] && !st_i.flags[RF_BAD] && !st_i.flags[RF_OVF]
                 && (!st_i.flags[RF_NEG] || (st_i.accum == 31'd0));
  assign fk       = name_resolve(st_i.cand, st_i.pos);

  always_comb begin
    st_o      = st_i;
    res_vld_o = 1'b0;
    res_o     = '0;
    case (st_i.phase)
      PH_START: begin
        if (byte_i == CH_LF) begin
          if (st_i.has_field) begin
            res_vld_o       = 1'b1;
            res_o.kind      = K_DISPATCH;
            st_o.has_field  = 1'b0;
            st_o.data_ne    = 1'b0;
          end
        end else if (byte_i == CH_COLON) begin
          st_o.phase = PH_SKIP;
        end else begin
          st_o.cand  = name_step(4'hF, 3'd0, byte_i);
          st_o.pos   = 3'd1;
          st_o.phase = PH_NAME;
        end
      end
      PH_NAME: begin
        if ((byte_i == CH_COLON) || (byte_i == CH_LF)) begin
          st_o.fkind = fk;
          case (fk)
            FK_DATA: begin
              st_o.has_field = 1'b1;
              if (st_i.data_ne) begin
                res_vld_o      = 1'b1;
                res_o.kind     = K_DATA;
                res_o.out_byte = CH_LF;
              end
            end
            FK_ID: begin
              st_o.has_field = 1'b1;
              res_vld_o      = 1'b1;
              res_o.kind     = K_ID_CLR;
            end
            FK_EVENT: begin
              st_o.has_field = 1'b1;
              res_vld_o      = 1'b1;
              res_o.kind     = K_EVENT_CLR;
            end
            FK_RETRY: begin
              st_o.accum = 31'd0;
              st_o.flags = 4'd0;
            end
            default: begin
            end
          endcase
          // A retry line ending here has no digits, so it is always rejected.
          if (byte_i == CH_LF) begin
            st_o.fkind = FK_NONE;
            st_o.phase = PH_START;
          end else begin
            st_o.vfirst = 1'b1;
            st_o.phase  = (fk == FK_NONE) ? PH_SKIP : PH_VALUE;
          end
        end else begin
          st_o.cand = name_step(st_i.cand, st_i.pos, byte_i);
          if (st_i.pos != 3'd7) begin
            st_o.pos = st_i.pos + 3'd1;
          end
        end
      end
      PH_VALUE: begin
        st_o.vfirst = 1'b0;
        if (byte_i == CH_LF) begin
          if ((st_i.fkind == FK_RETRY) && close_ok) begin
            st_o.has_field    = 1'b1;
            res_vld_o         = 1'b1;
            res_o.kind        = K_RETRY;
            res_o.retry_value = st_i.accum;
          end
          st_o.fkind = FK_NONE;
          st_o.phase = PH_START;
        end else if (!(st_i.vfirst && (byte_i == CH_SPACE))) begin
          case (st_i.fkind)
            FK_DATA: begin
              st_o.data_ne   = 1'b1;
              res_vld_o      = 1'b1;
              res_o.kind     = K_DATA;
              res_o.out_byte = byte_i;
            end
            FK_ID: begin
              res_vld_o      = 1'b1;
              res_o.kind     = K_ID;
              res_o.out_byte = byte_i;
            end
            FK_EVENT: begin
              res_vld_o      = 1'b1;
              res_o.kind     = K_EVENT;
              res_o.out_byte = byte_i;
            end
            FK_RETRY: begin
              if ((byte_i == CH_MINUS) && !st_i.flags[RF_NEG] && !st_i.flags[RF_DIGIT]) begin
                st_o.flags[RF_NEG] = 1'b1;
              end else if (is_digit) begin
                st_o.flags[RF_DIGIT] = 1'b1;
                if (!st_i.flags[RF_OVF]) begin
                  if (ovf) begin
                    st_o.flags[RF_OVF] = 1'b1;
                  end else begin
                    st_o.accum = prod[30:0];
                  end
                end
              end else begin
                st_o.flags[RF_BAD] = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        if (byte_i == CH_LF) begin
          st_o.phase = PH_START;
        end
      end
    endcase
  end

endmodule

/* rtl/core/sse_out_buf.sv */
module sse_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic [1:0]        load_cnt_i,
  input  sse_pkg::sse_out_t res_a_i,
  input  sse_pkg::sse_out_t res_b_i,
  output logic              space_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sse_pkg::sse_out_t out_data_o
);
  import sse_pkg::*;

  sse_out_t   slot_q [2];
  sse_out_t   slot_d [2];
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop         = (cnt_q != 2'd0) && !out_stall_i;
  assign space_o     = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);
  assign out_valid_o = cnt_q != 2'd0;
  assign out_data_o  = slot_q[0];

  always_comb begin
    slot_d[0] = slot_q[0];
    slot_d[1] = slot_q[1];
    cnt_d     = cnt_q;
    if (load_i && space_o) begin
      slot_d[0] = res_a_i;
      slot_d[1] = res_b_i;
      cnt_d     = load_cnt_i;
    end else if (pop) begin
      slot_d[0] = slot_q[1];
      cnt_d     = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q[0] <= slot_d[0];
    slot_q[1] <= slot_d[1];
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result buffer holds more than two requests");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !slot_q[0].last && slot_q[1].last)
    else $error("first of a result pair is marked last or second is not");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result request changed or was dropped");

endmodule

/* rtl/core/sse_event_stream_parser_core.sv */
// Channel | Handshake                 | Payload
// input   | in_valid_i / in_stall_o   | in_data_i, sse_in_t: func, in_byte
// output  | out_valid_o / out_stall_i | out_data_o, sse_out_t: kind, out_byte, retry_value, last
//
// One byte is accepted per cycle while in_stall_o is low. A byte that completes a held CR as
// something other than a line end can produce two results, and the two-entry result buffer
// then holds both and presents them one after the other. A result passes through the input
// register and then the result buffer before it can be taken.
// Reset clears the parser state, the held CR and both handshake stages.
// A stalled output backs up through the result buffer into the input register.
module sse_event_stream_parser_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sse_pkg::sse_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sse_pkg::sse_out_t out_data_o
);
  import sse_pkg::*;

  logic       in_vld_q;
  sse_in_t    in_q;
  sse_state_t st_q, st_d;
  logic       cr_held_q, cr_held_d;

  logic       en0, en1;
  sse_state_t st0, st1, st_mid;
  logic       vld0, vld1;
  sse_out_t   res0, res1;
  sse_out_t   res_a, res_b;
  logic [1:0] n_res;
  logic       space;
  logic       advance;
  logic       accept;

  // The held CR is replayed as an ordinary byte unless this byte is the LF it belongs to.
  assign en0 = !in_q.func && cr_held_q && (in_q.in_byte != CH_LF);
  assign en1 = !in_q.func && (in_q.in_byte != CH_CR);

  sse_feed u_feed_cr (
    .st_i      (st_q),
    .byte_i    (CH_CR),
    .st_o      (st0),
    .res_vld_o (vld0),
    .res_o     (res0)
  );

  assign st_mid = en0 ? st0 : st_q;

  sse_feed u_feed_byte (
    .st_i      (st_mid),
    .byte_i    (in_q.in_byte),
    .st_o      (st1),
    .res_vld_o (vld1),
    .res_o     (res1)
  );

  always_comb begin
    res_a = '0;
    res_b = '0;
    n_res = 2'd0;
    if (in_q.func) begin
      st_d       = STATE_RESET;
      cr_held_d  = 1'b0;
      res_a.kind = K_DISCARD;
      res_a.last = 1'b1;
      n_res      = 2'd1;
    end else begin
      st_d      = en1 ? st1 : st_mid;
      cr_held_d = in_q.in_byte == CH_CR;
      if (en0 && vld0 && en1 && vld1) begin
        res_a      = res0;
        res_b      = res1;
        res_b.last = 1'b1;
        n_res      = 2'd2;
      end else if (en0 && vld0) begin
        res_a      = res0;
        res_a.last = 1'b1;
        n_res      = 2'd1;
      end else if (en1 && vld1) begin
        res_a      = res1;
        res_a.last = 1'b1;
        n_res      = 2'd1;
      end
    end
  end

  assign advance    = in_vld_q && ((n_res == 2'd0) || space);
  assign in_stall_o = in_vld_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  sse_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && (n_res != 2'd0)),
    .load_cnt_i  (n_res),
    .res_a_i     (res_a),
    .res_b_i     (res_b),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      st_q      <= STATE_RESET;
      cr_held_q <= 1'b0;
    end else begin
      if (accept) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        st_q      <= st_d;
        cr_held_q <= cr_held_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_q.func |=> !cr_held_q && (st_q.phase == PH_START) && !st_q.has_field)
    else $error("restart request did not clear the parser state");

  a_cr_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !in_q.func && (in_q.in_byte == CH_CR) |=> cr_held_q)
    else $error("CR request was not held");

  a_data_implies_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.data_ne |-> st_q.has_field)
    else $error("event data present without a field seen");

endmodule
